@@ hw/rtl/rptb_pkg.sv @@
package rptb_pkg;

   // bank size and counter width
   localparam int NUM_CHANNELS = 16;
   localparam int TIMER_BITS   = 16;

   // field widths of the transaction ports
   localparam int MODE_W    = 3;
   localparam int CHANNEL_W = 5;
   localparam int DUR_W     = 16;
   localparam int MASK_W    = 16;
   localparam int ERR_W     = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   // largest value a down-counter holds
   localparam logic [31:0] TIMER_MAX = 32'((64'(1) << TIMER_BITS) - 64'(1));

   // command codes
   localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FIRE_ONE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIRE_MASK = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RAW_SET   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP      = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RELEASE   = 3'd5;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_STOPPED   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_RANGE     = 3'd2;
   localparam logic [ERR_W-1:0] ERR_DURATION  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_LOCKED    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVEL = 1'b1;

   // register reset values
   localparam logic [DUR_W-1:0] MAX_PULSE_RESET = 16'd2000;

   // per-transaction command to the channel bank
   typedef struct packed {
      logic                    tick;
      logic                    stop;
      logic                    raw_closed;
      logic [TIMER_BITS-1:0]   load;
      logic [NUM_CHANNELS-1:0] fire;
      logic [NUM_CHANNELS-1:0] raw;
   } bank_cmd_type;

   // saturate a requested duration to the counter range
   function automatic logic [TIMER_BITS-1:0] counter_load(input logic [DUR_W-1:0] dur);
      logic [31:0] d32;
      d32 = 32'(dur);
      if (d32 > TIMER_MAX) begin
         return '1;
      end
      return d32[TIMER_BITS-1:0];
   endfunction

endpackage

@@ hw/rtl/rptb_decode.sv @@
module rptb_decode
   import rptb_pkg::*;
(
   input  logic [MODE_W-1:0]    mode,
   input  logic [CHANNEL_W-1:0] channel,
   input  logic [DUR_W-1:0]     duration_ms,
   input  logic [MASK_W-1:0]    fire_mask,
   input  logic                 raw_level,
   input  logic                 gpio_locked,
   input  logic                 stop_flag,
   input  logic [DUR_W-1:0]     max_pulse_ms,
   input  logic                 active_level,
   output bank_cmd_type         cmd,
   output logic                 accepted,
   output logic [ERR_W-1:0]     error_code,
   output logic                 stop_next
);

   logic                    in_range;
   logic                    dur_ok;
   logic [NUM_CHANNELS-1:0] chan_sel;

   // one-hot select of the one-based channel number
   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         chan_sel[i] = (channel == CHANNEL_W'(i + 1));
      end
   end

   assign in_range = (channel != '0) && (channel <= CHANNEL_W'(NUM_CHANNELS));
   assign dur_ok   = (duration_ms != '0) && (duration_ms <= max_pulse_ms);

   // checks in order: stop latch, range (single fire only), duration (or jumper, range for raw set)
   always_comb begin
      cmd            = '0;
      cmd.load       = counter_load(duration_ms);
      cmd.raw_closed = (raw_level == active_level);
      accepted       = 1'b0;
      error_code     = ERR_NONE;
      stop_next      = stop_flag;
      unique case (mode)
         MODE_TICK: begin
            cmd.tick = 1'b1;
            accepted = 1'b1;
         end
         MODE_FIRE_ONE: begin
            if (stop_flag) begin
               error_code = ERR_STOPPED;
            end else if (!in_range) begin
               error_code = ERR_RANGE;
            end else if (!dur_ok) begin
               error_code = ERR_DURATION;
            end else begin
               cmd.fire = chan_sel;
               accepted = 1'b1;
            end
         end
         MODE_FIRE_MASK: begin
            if (stop_flag) begin
               error_code = ERR_STOPPED;
            end else if (!dur_ok) begin
               error_code = ERR_DURATION;
            end else begin
               cmd.fire = fire_mask[NUM_CHANNELS-1:0];
               accepted = 1'b1;
            end
         end
         MODE_RAW_SET: begin
            if (gpio_locked) begin
               error_code = ERR_LOCKED;
            end else if (!in_range) begin
               error_code = ERR_RANGE;
            end else begin
               cmd.raw  = chan_sel;
               accepted = 1'b1;
            end
         end
         MODE_STOP: begin
            cmd.stop  = 1'b1;
            stop_next = 1'b1;
            accepted  = 1'b1;
         end
         MODE_RELEASE: begin
            stop_next = 1'b0;
            accepted  = 1'b1;
         end
         default: begin
            accepted = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/rptb_channel.sv @@
module rptb_channel
   import rptb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  bank_cmd_type cmd,
   input  logic         fire_sel,
   input  logic         raw_sel,
   output logic         closed_in
);

   logic [TIMER_BITS-1:0] remaining_ff;
   logic [TIMER_BITS-1:0] remaining_in;
   logic                  closed_ff;

   // next timer and relay state for this channel
   always_comb begin
      remaining_in = remaining_ff;
      closed_in    = closed_ff;
      priority if (cmd.stop) begin
         remaining_in = '0;
         closed_in    = 1'b0;
      end else if (fire_sel) begin
         remaining_in = cmd.load;
         closed_in    = 1'b1;
      end else if (raw_sel) begin
         remaining_in = '0;
         closed_in    = cmd.raw_closed;
      end else if (cmd.tick && (remaining_ff != '0)) begin
         remaining_in = remaining_ff - TIMER_BITS'(1);
         if (remaining_ff == TIMER_BITS'(1)) begin
            closed_in = 1'b0;
         end
      end else begin
         // nothing for this channel: hold
         remaining_in = remaining_ff;
         closed_in    = closed_ff;
      end
   end

   // state moves only when a transaction passes to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         closed_ff    <= 1'b0;
      end else if (advance) begin
         remaining_ff <= remaining_in;
         closed_ff    <= closed_in;
      end
   end

endmodule

@@ hw/rtl/relay_pulse_timer_bank_estop.sv @@
// Bank of sixteen relay channels, each a one-shot pulse timer, with a shared
// emergency stop latch. One transaction can be taken every clock cycle while
// results keep draining; an accepted transaction waits in the input register
// and moves to the result register once that register is empty or its result
// is taken, and its result is offered from there. The sixteen down-counters,
// the stop latch and the result all update together as it moves across.
// While a result is stalled the input register can still fill; once both hold
// a transaction, req_stall rises until the result is taken. Register writes on
// the csr_ port take effect at once and are meant for when no transaction is
// in flight. drive_levels follow active_level as it stood when the
// transaction was processed.
module relay_pulse_timer_bank_estop
   import rptb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // command transactions
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [CHANNEL_W-1:0] req_channel,
   input  logic [DUR_W-1:0]     req_duration_ms,
   input  logic [MASK_W-1:0]    req_fire_mask,
   input  logic                 req_raw_level,
   input  logic                 req_gpio_locked,
   // result transactions
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_accepted,
   output logic [ERR_W-1:0]     rsp_error_code,
   output logic [MASK_W-1:0]    rsp_closed_mask,
   output logic [MASK_W-1:0]    rsp_drive_levels,
   output logic                 rsp_stop_latched,
   // register writes
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_write_data
);

   logic [DUR_W-1:0]     max_pulse_ff;
   logic                 active_level_ff;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [CHANNEL_W-1:0] channel_ff;
   logic [DUR_W-1:0]     duration_ff;
   logic [MASK_W-1:0]    fire_mask_ff;
   logic                 raw_level_ff;
   logic                 gpio_locked_ff;

   logic                 stop_ff;
   logic                 stop_in;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 accepted_ff;
   logic                 accepted_in;
   logic [ERR_W-1:0]     error_ff;
   logic [ERR_W-1:0]     error_in;
   logic [MASK_W-1:0]    closed_mask_ff;
   logic [MASK_W-1:0]    drive_ff;

   logic                    take_req;
   logic                    advance;
   bank_cmd_type            cmd;
   logic [NUM_CHANNELS-1:0] closed_vec;
   logic [NUM_CHANNELS-1:0] drive_vec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_pulse_ff    <= MAX_PULSE_RESET;
         active_level_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_PULSE:    max_pulse_ff    <= csr_write_data[DUR_W-1:0];
            CSR_ACTIVE_LEVEL: active_level_ff <= csr_write_data[0];
            default:          max_pulse_ff    <= max_pulse_ff;
         endcase
      end
   end

   // handshake: the input register drains whenever the result register can load
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign take_req     = req_valid && !req_stall;
   assign in_valid_in  = take_req || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         mode_ff        <= req_mode;
         channel_ff     <= req_channel;
         duration_ff    <= req_duration_ms;
         fire_mask_ff   <= req_fire_mask;
         raw_level_ff   <= req_raw_level;
         gpio_locked_ff <= req_gpio_locked;
      end
   end

   // command checks
   rptb_decode u_decode (
      .mode         (mode_ff),
      .channel      (channel_ff),
      .duration_ms  (duration_ff),
      .fire_mask    (fire_mask_ff),
      .raw_level    (raw_level_ff),
      .gpio_locked  (gpio_locked_ff),
      .stop_flag    (stop_ff),
      .max_pulse_ms (max_pulse_ff),
      .active_level (active_level_ff),
      .cmd          (cmd),
      .accepted     (accepted_in),
      .error_code   (error_in),
      .stop_next    (stop_in)
   );

   // channel timers
   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
      rptb_channel u_channel (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .cmd       (cmd),
         .fire_sel  (cmd.fire[g]),
         .raw_sel   (cmd.raw[g]),
         .closed_in (closed_vec[g])
      );
   end

   // closed channels drive active_level, open ones its inverse
   assign drive_vec = closed_vec ^ {NUM_CHANNELS{~active_level_ff}};

   // stop latch
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff <= 1'b0;
      end else if (advance) begin
         stop_ff <= stop_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         accepted_ff    <= accepted_in;
         error_ff       <= error_in;
         closed_mask_ff <= MASK_W'(closed_vec);
         drive_ff       <= MASK_W'(drive_vec);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_accepted     = accepted_ff;
   assign rsp_error_code   = error_ff;
   assign rsp_closed_mask  = closed_mask_ff;
   assign rsp_drive_levels = drive_ff;
   assign rsp_stop_latched = stop_ff;

endmodule

@@ hw/rtl/rptb_checker.sv @@
module rptb_checker
   import rptb_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [MODE_W-1:0]    req_mode,
   input logic [CHANNEL_W-1:0] req_channel,
   input logic [DUR_W-1:0]     req_duration_ms,
   input logic [MASK_W-1:0]    req_fire_mask,
   input logic                 req_raw_level,
   input logic                 req_gpio_locked,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_accepted,
   input logic [ERR_W-1:0]     rsp_error_code,
   input logic [MASK_W-1:0]    rsp_closed_mask,
   input logic [MASK_W-1:0]    rsp_drive_levels,
   input logic                 rsp_stop_latched,
   input logic                 csr_write_enable,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_DAT_W-1:0] csr_write_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_closed_mask)
         && $stable(rsp_error_code) && $stable(rsp_drive_levels))
      else $error("stalled result changed");

   // every pin is either at the closing level or its inverse, consistently
   a_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_levels == rsp_closed_mask)
         || (rsp_drive_levels == ~rsp_closed_mask))
      else $error("drive levels disagree with closed mask");

   // a carried-out command reports no error
   a_acc_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_error_code == ERR_NONE)
      else $error("accepted command with error code");

   // a stop-latched rejection implies the latch is set
   a_stop_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_STOPPED) |-> rsp_stop_latched)
      else $error("stop error without latched stop");

endmodule

bind relay_pulse_timer_bank_estop rptb_checker u_rptb_checker (.*);

@@ verif/relay_pulse_timer_bank_estop_tb.sv @@
module relay_pulse_timer_bank_estop_tb;
   import rptb_pkg::*;

   // spare command codes the block must ignore
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 6;
   localparam int HOLD_CYCLES    = 160;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_ITEMS    = 280;
   localparam int SWEEP_ITEMS    = 40;
   localparam int PRESSURE_ITEMS = 40;
   localparam int PRINT_LIMIT    = 40;

   // one command transaction
   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [CHANNEL_W-1:0] channel;
      logic [DUR_W-1:0]     duration;
      logic [MASK_W-1:0]    fire_mask;
      logic                 raw_level;
      logic                 gpio_locked;
   } relay_cmd_type;

   // one status transaction
   typedef struct packed {
      logic              accepted;
      logic [ERR_W-1:0]  error_code;
      logic [MASK_W-1:0] closed_mask;
      logic [MASK_W-1:0] drive_levels;
      logic              stop_latched;
   } relay_status_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [MODE_W-1:0]    req_mode;
   logic [CHANNEL_W-1:0] req_channel;
   logic [DUR_W-1:0]     req_duration_ms;
   logic [MASK_W-1:0]    req_fire_mask;
   logic                 req_raw_level;
   logic                 req_gpio_locked;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_accepted;
   logic [ERR_W-1:0]     rsp_error_code;
   logic [MASK_W-1:0]    rsp_closed_mask;
   logic [MASK_W-1:0]    rsp_drive_levels;
   logic                 rsp_stop_latched;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_write_data;

   // shadow of the bank
   logic [DUR_W-1:0]      shadow_max_pulse;
   logic                  shadow_active_level;
   logic                  shadow_estop;
   logic [TIMER_BITS-1:0] shadow_timer [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] shadow_closed;

   relay_status_type expected_status [$];

   bit          idle_on;
   bit          hold_request;
   int          hold_count;
   int unsigned cycle_count;
   int unsigned sent_count;
   int unsigned checked_count;
   int unsigned setting_count;
   int unsigned error_count;
   int unsigned error_seen [8];
   int unsigned mode_seen [8];

   relay_pulse_timer_bank_estop u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_channel      (req_channel),
      .req_duration_ms  (req_duration_ms),
      .req_fire_mask    (req_fire_mask),
      .req_raw_level    (req_raw_level),
      .req_gpio_locked  (req_gpio_locked),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_error_code   (rsp_error_code),
      .rsp_closed_mask  (rsp_closed_mask),
      .rsp_drive_levels (rsp_drive_levels),
      .rsp_stop_latched (rsp_stop_latched),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_status.size());
         $display("relay_pulse_timer_bank_estop_tb: errors");
         $finish;
      end
   end

   // shadow back to its reset state
   function automatic void clear_shadow();
      shadow_max_pulse    = MAX_PULSE_RESET;
      shadow_active_level = 1'b0;
      shadow_estop        = 1'b0;
      shadow_closed       = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         shadow_timer[i] = '0;
      end
   endfunction

   // carry out one command on the shadow and work out the status it reports
   function automatic relay_status_type apply_command(relay_cmd_type c);
      relay_status_type s;
      logic in_range;
      logic dur_ok;
      logic [TIMER_BITS-1:0] load;
      int idx;
      s = '0;
      idx = int'(c.channel) - 1;
      in_range = (c.channel >= 1) && (int'(c.channel) <= NUM_CHANNELS);
      dur_ok = (c.duration != '0) && (c.duration <= shadow_max_pulse);
      load = (32'(c.duration) > TIMER_MAX) ? TIMER_BITS'(TIMER_MAX) : TIMER_BITS'(c.duration);
      case (c.mode)
         MODE_TICK: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (shadow_timer[i] != '0) begin
                  shadow_timer[i] = shadow_timer[i] - TIMER_BITS'(1);
                  if (shadow_timer[i] == '0) begin
                     shadow_closed[i] = 1'b0;
                  end
               end
            end
            s.accepted = 1'b1;
         end
         MODE_FIRE_ONE: begin
            if (shadow_estop) begin
               s.error_code = ERR_STOPPED;
            end else if (!in_range) begin
               s.error_code = ERR_RANGE;
            end else if (!dur_ok) begin
               s.error_code = ERR_DURATION;
            end else begin
               shadow_closed[idx] = 1'b1;
               shadow_timer[idx]  = load;
               s.accepted = 1'b1;
            end
         end
         MODE_FIRE_MASK: begin
            if (shadow_estop) begin
               s.error_code = ERR_STOPPED;
            end else if (!dur_ok) begin
               s.error_code = ERR_DURATION;
            end else begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (c.fire_mask[i]) begin
                     shadow_closed[i] = 1'b1;
                     shadow_timer[i]  = load;
                  end
               end
               s.accepted = 1'b1;
            end
         end
         MODE_RAW_SET: begin
            if (c.gpio_locked) begin
               s.error_code = ERR_LOCKED;
            end else if (!in_range) begin
               s.error_code = ERR_RANGE;
            end else begin
               shadow_closed[idx] = (c.raw_level == shadow_active_level);
               shadow_timer[idx]  = '0;
               s.accepted = 1'b1;
            end
         end
         MODE_STOP: begin
            shadow_estop  = 1'b1;
            shadow_closed = '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               shadow_timer[i] = '0;
            end
            s.accepted = 1'b1;
         end
         MODE_RELEASE: begin
            shadow_estop = 1'b0;
            s.accepted = 1'b1;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         s.closed_mask[i]  = shadow_closed[i];
         s.drive_levels[i] = shadow_closed[i] ? shadow_active_level : ~shadow_active_level;
      end
      s.stop_latched = shadow_estop;
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch on %s at result %0d: expected %h, got %h", what, checked_count,
                  want, got);
      end
      error_count++;
   endtask

   // watch both channels and the register port at each rising edge
   always @(posedge clock) begin
      relay_cmd_type c;
      relay_status_type want;
      if (reset) begin
         clear_shadow();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAX_PULSE:    shadow_max_pulse = csr_write_data[DUR_W-1:0];
               CSR_ACTIVE_LEVEL: shadow_active_level = csr_write_data[0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               report_mismatch("status with nothing outstanding", '0, '0);
            end else begin
               want = expected_status.pop_front();
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", 32'(want.accepted), 32'(rsp_accepted));
               if (rsp_error_code !== want.error_code)
                  report_mismatch("error_code", 32'(want.error_code), 32'(rsp_error_code));
               if (rsp_closed_mask !== want.closed_mask)
                  report_mismatch("closed_mask", 32'(want.closed_mask),
                                  32'(rsp_closed_mask));
               if (rsp_drive_levels !== want.drive_levels)
                  report_mismatch("drive_levels", 32'(want.drive_levels),
                                  32'(rsp_drive_levels));
               if (rsp_stop_latched !== want.stop_latched)
                  report_mismatch("stop_latched", 32'(want.stop_latched),
                                  32'(rsp_stop_latched));
               error_seen[want.error_code]++;
               checked_count++;
            end
         end
         if (req_valid && !req_stall) begin
            c.mode        = req_mode;
            c.channel     = req_channel;
            c.duration    = req_duration_ms;
            c.fire_mask   = req_fire_mask;
            c.raw_level   = req_raw_level;
            c.gpio_locked = req_gpio_locked;
            mode_seen[c.mode]++;
            expected_status.push_back(apply_command(c));
         end
      end
   end

   // receiver: random stall bursts, or one long counted hold-off on request
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
               @(negedge clock);
            end
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   function automatic relay_cmd_type make_cmd(logic [MODE_W-1:0] mode, int channel,
                                              int duration, logic [MASK_W-1:0] fire_mask,
                                              logic raw_level, logic gpio_locked);
      relay_cmd_type c;
      c.mode        = mode;
      c.channel     = CHANNEL_W'(channel);
      c.duration    = DUR_W'(duration);
      c.fire_mask   = fire_mask;
      c.raw_level   = raw_level;
      c.gpio_locked = gpio_locked;
      return c;
   endfunction

   // mostly well-formed commands with random content, some noise
   function automatic relay_cmd_type random_command();
      relay_cmd_type c;
      int pick;
      int top;
      c.channel     = CHANNEL_W'($urandom);
      c.duration    = DUR_W'($urandom);
      c.fire_mask   = MASK_W'($urandom);
      c.raw_level   = 1'($urandom);
      c.gpio_locked = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 36)      c.mode = MODE_TICK;
      else if (pick < 58) c.mode = MODE_FIRE_ONE;
      else if (pick < 70) c.mode = MODE_FIRE_MASK;
      else if (pick < 82) c.mode = MODE_RAW_SET;
      else if (pick < 86) c.mode = MODE_STOP;
      else if (pick < 96) c.mode = MODE_RELEASE;
      else                c.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      if ($urandom_range(0, 9) < 8) begin
         // short pulses so that ticks actually run timers out
         top = (int'(shadow_max_pulse) < 24) ? int'(shadow_max_pulse) : 24;
         c.channel  = CHANNEL_W'($urandom_range(1, NUM_CHANNELS));
         c.duration = DUR_W'($urandom_range(1, top));
         if ($urandom_range(0, 1) == 0) c.fire_mask = c.fire_mask & MASK_W'($urandom);
         if ($urandom_range(0, 3) != 0) c.gpio_locked = 1'b0;
      end
      return c;
   endfunction

   // offer one command and hold it until the block takes it
   task automatic send_command(relay_cmd_type c);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_mode        <= c.mode;
      req_channel     <= c.channel;
      req_duration_ms <= c.duration;
      req_fire_mask   <= c.fire_mask;
      req_raw_level   <= c.raw_level;
      req_gpio_locked <= c.gpio_locked;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_random(int count);
      repeat (count) send_command(random_command());
   endtask

   // stop offering and let every outstanding status come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write both registers, only with the bank idle
   task automatic write_registers(int max_pulse, logic active_level);
      logic [CSR_DAT_W-1:0] level_word;
      drain_results();
      level_word = CSR_DAT_W'($urandom);
      level_word[0] = active_level;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MAX_PULSE;
      csr_write_data   <= CSR_DAT_W'(max_pulse);
      @(negedge clock);
      csr_index        <= CSR_ACTIVE_LEVEL;
      csr_write_data   <= level_word;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      setting_count++;
   endtask

   // reset settings: duration limit boundary and a stop cycle
   task automatic test_reset_state();
      send_command(make_cmd(MODE_TICK, 0, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_ONE, 1, int'(MAX_PULSE_RESET), '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_ONE, 2, int'(MAX_PULSE_RESET) + 1, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_STOP, 0, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_RELEASE, 0, 0, '0, 1'b0, 1'b0));
      drain_results();
   endtask

   // every command, field extremes and the check order of each error
   task automatic test_command_corners();
      // one-tick pulse opens on the first tick
      send_command(make_cmd(MODE_FIRE_ONE, 1, 1, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_TICK, 31, 65535, '1, 1'b1, 1'b1));
      send_command(make_cmd(MODE_FIRE_ONE, NUM_CHANNELS, 2000, '0, 1'b0, 1'b0));
      // range before duration, then duration limits
      send_command(make_cmd(MODE_FIRE_ONE, 0, 5, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_ONE, NUM_CHANNELS + 1, 5, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_ONE, 31, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_ONE, 2, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_ONE, 2, 2001, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_ONE, 3, 65535, '0, 1'b1, 1'b1));
      // empty mask, full mask, bad duration on a mask
      send_command(make_cmd(MODE_FIRE_MASK, 0, 5, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_MASK, 0, 3, '1, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_MASK, 0, 0, '1, 1'b0, 1'b0));
      repeat (3) send_command(make_cmd(MODE_TICK, 0, 0, '0, 1'b0, 1'b0));
      // raw set: jumper before range
      send_command(make_cmd(MODE_RAW_SET, 0, 0, '0, 1'b0, 1'b1));
      send_command(make_cmd(MODE_RAW_SET, 0, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_RAW_SET, NUM_CHANNELS + 1, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_RAW_SET, 5, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_RAW_SET, NUM_CHANNELS, 1, '0, 1'b1, 1'b0));
      // stop latched: fire blocked ahead of range and duration, raw set still works
      send_command(make_cmd(MODE_STOP, 0, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_ONE, 0, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_MASK, 0, 0, '1, 1'b0, 1'b0));
      send_command(make_cmd(MODE_RAW_SET, 4, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_RELEASE, 0, 0, '0, 1'b0, 1'b0));
      // spare codes are ignored
      send_command(make_cmd(MODE_SPARE_LO, 3, 7, 16'h00ff, 1'b1, 1'b0));
      send_command(make_cmd(MODE_SPARE_HI, 9, 1, 16'hff00, 1'b0, 1'b1));
      drain_results();
   endtask

   // register extremes: shortest limit with active high, then the longest limit
   task automatic test_register_extremes();
      write_registers(1, 1'b1);
      send_command(make_cmd(MODE_FIRE_ONE, 1, 1, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_ONE, 2, 2, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_MASK, 0, 1, 16'h8001, 1'b0, 1'b0));
      send_command(make_cmd(MODE_RAW_SET, 3, 0, '0, 1'b1, 1'b0));
      send_command(make_cmd(MODE_RAW_SET, 4, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_TICK, 0, 0, '0, 1'b0, 1'b0));
      send_random(SWEEP_ITEMS);
      write_registers(65535, 1'b0);
      send_command(make_cmd(MODE_FIRE_ONE, 7, 65535, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_FIRE_MASK, 0, 65535, 16'ha5a5, 1'b0, 1'b0));
      send_command(make_cmd(MODE_TICK, 0, 0, '0, 1'b0, 1'b0));
      send_random(SWEEP_ITEMS);
      send_command(make_cmd(MODE_STOP, 0, 0, '0, 1'b0, 1'b0));
      send_command(make_cmd(MODE_RELEASE, 0, 0, '0, 1'b0, 1'b0));
      drain_results();
   endtask

   // long receiver hold-off while commands keep coming
   task automatic test_backpressure();
      write_registers(40, 1'b0);
      hold_request = 1'b1;
      send_random(PRESSURE_ITEMS);
      drain_results();
   endtask

   // random traffic over several register settings, third and last phases at full rate
   task automatic test_random_traffic();
      int limit;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case ($urandom_range(0, 4))
            0:       limit = 1;
            1:       limit = $urandom_range(2, 40);
            2:       limit = $urandom_range(200, 2000);
            3:       limit = 65535;
            default: limit = $urandom_range(1, 65535);
         endcase
         write_registers(limit, 1'($urandom));
         idle_on = (phase != PHASE_COUNT - 1) && (phase % 3 != 2);
         send_random(PHASE_ITEMS);
      end
      drain_results();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_TICK;
      req_channel      = '0;
      req_duration_ms  = '0;
      req_fire_mask    = '0;
      req_raw_level    = 1'b0;
      req_gpio_locked  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_MAX_PULSE;
      csr_write_data   = '0;
      idle_on          = 1'b1;
      hold_request     = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_command_corners();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();

      $display("covered %0d commands (tick %0d, fire %0d, mask %0d, raw %0d, stop %0d, %s %0d)",
               sent_count, mode_seen[MODE_TICK], mode_seen[MODE_FIRE_ONE],
               mode_seen[MODE_FIRE_MASK], mode_seen[MODE_RAW_SET], mode_seen[MODE_STOP],
               "release", mode_seen[MODE_RELEASE]);
      $display("%0d statuses checked over %0d register settings; %s %0d/%0d/%0d/%0d/%0d",
               checked_count, setting_count, "errors none/stop/range/dur/lock",
               error_seen[ERR_NONE], error_seen[ERR_STOPPED], error_seen[ERR_RANGE],
               error_seen[ERR_DURATION], error_seen[ERR_LOCKED]);
      if (error_count == 0 && expected_status.size() == 0) begin
         $display("relay_pulse_timer_bank_estop_tb: clean");
      end else begin
         $display("relay_pulse_timer_bank_estop_tb: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/rptb_pkg.sv
hw/rtl/rptb_decode.sv
hw/rtl/rptb_channel.sv
hw/rtl/relay_pulse_timer_bank_estop.sv
hw/rtl/rptb_checker.sv
verif/relay_pulse_timer_bank_estop_tb.sv
